FILE: src/rsw_pkg.sv
// Shared types and constants of the run-length span window decoder.
`default_nettype none
package rsw_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_WORD  = 1'b1
  } rsw_op_t;

  typedef enum logic {
    KIND_LITERAL = 1'b0,
    KIND_FILL    = 1'b1
  } rsw_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_LIT    = 3'd3,
    PH_DONE   = 3'd4
  } rsw_phase_t;

  typedef struct packed {
    logic               op;
    logic [14:0]        start_pos;
    logic [9:0]         window_count;
    logic signed [15:0] data_word;
  } rsw_in_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [9:0]  span_length;
    logic [9:0]  dest_index;
    logic        last;
  } rsw_out_t;

  // Classified request as held in the queue between front and back.
  typedef struct packed {
    logic        is_start;
    logic [14:0] start_pos;
    logic [9:0]  window_count;
    logic        window_zero;
    logic [15:0] raw_word;
    logic        fill_run;
    logic [15:0] run_len;
  } rsw_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rsw_q_status_t;

endpackage : rsw_pkg
`default_nettype wire

FILE: src/rsw_front.sv
// Front end: accept requests and classify them into queue commands.
`default_nettype none
module rsw_front #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire                    in_valid,
  output logic                   in_stall,
  input  rsw_pkg::rsw_in_t       in_data,
  input  rsw_pkg::rsw_q_status_t q_status,
  output logic                   push,
  output rsw_pkg::rsw_cmd_t      push_cmd
);
  import rsw_pkg::*;

  localparam int WcMax = MAX_WINDOW - 1;

  logic [12:0] wc_ext;
  logic [12:0] wc_max_ext;
  logic [9:0]  wc_clip;
  logic [15:0] raw;
  logic        negative;

  assign in_stall   = q_status.full;
  assign push       = in_valid && !q_status.full;

  assign wc_ext     = {3'b000, in_data.window_count};
  assign wc_max_ext = 13'(WcMax);
  assign wc_clip    = (wc_ext > wc_max_ext) ? wc_max_ext[9:0] : in_data.window_count;

  assign raw        = in_data.data_word;
  assign negative   = raw[15];

  always_comb begin
    push_cmd.is_start     = (in_data.op == OP_START);
    push_cmd.start_pos    = in_data.start_pos;
    push_cmd.window_count = wc_clip;
    push_cmd.window_zero  = (wc_clip == 10'd0);
    push_cmd.raw_word     = raw;
    push_cmd.fill_run     = negative;
    // magnitude of a fill header; a literal header is its own count
    push_cmd.run_len      = negative ? (16'd0 - raw) : raw;
  end

endmodule : rsw_front
`default_nettype wire

FILE: src/rsw_queue.sv
// Short command queue between the front end and the decode back end.
`default_nettype none
module rsw_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  rsw_pkg::rsw_cmd_t      push_cmd,
  input  wire                    pop,
  output rsw_pkg::rsw_cmd_t      head_cmd,
  output rsw_pkg::rsw_q_status_t status
);
  import rsw_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  rsw_cmd_t        entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign status.full  = (count_r == CntW'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_cmd     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold payload, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule : rsw_queue
`default_nettype wire

FILE: src/rsw_back.sv
// Back end: run-length decode state machine and registered result.
`default_nettype none
module rsw_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire  [15:0]            cfg_wr_data,
  input  rsw_pkg::rsw_cmd_t      head_cmd,
  input  rsw_pkg::rsw_q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output rsw_pkg::rsw_out_t      out_data
);
  import rsw_pkg::*;

  logic [15:0] fill_value_r;
  rsw_phase_t  phase_r, phase_nxt;
  logic [14:0] row_pos_r, row_pos_nxt;
  logic [15:0] skip_left_r, skip_left_nxt;
  logic [15:0] run_left_r, run_left_nxt;
  logic        run_is_lit_r, run_is_lit_nxt;
  logic [9:0]  window_left_r, window_left_nxt;
  logic [9:0]  dest_pos_r, dest_pos_nxt;
  logic [14:0] target_r, target_nxt;
  logic        out_valid_r, out_valid_nxt;
  rsw_out_t    out_data_r, out_data_nxt;

  logic        advance;
  logic [16:0] run_end;
  logic [14:0] offset;
  logic [15:0] remain;
  logic [9:0]  fill_cnt;
  logic [9:0]  fill_left;
  logic [9:0]  lit_left;
  logic [15:0] skip_dec;

  assign advance   = !out_valid_r || !out_stall;
  assign pop       = advance && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign run_end   = {2'b00, row_pos_r} + {1'b0, head_cmd.run_len};
  assign offset    = target_r - row_pos_r;
  assign remain    = head_cmd.run_len - {1'b0, offset};
  assign fill_cnt  = (remain < {6'd0, window_left_r}) ? remain[9:0] : window_left_r;
  assign fill_left = window_left_r - fill_cnt;
  assign lit_left  = window_left_r - 10'd1;
  assign skip_dec  = (skip_left_r != 16'd0) ? skip_left_r - 16'd1 : skip_left_r;

  always_comb begin
    phase_nxt       = phase_r;
    row_pos_nxt     = row_pos_r;
    skip_left_nxt   = skip_left_r;
    run_left_nxt    = run_left_r;
    run_is_lit_nxt  = run_is_lit_r;
    window_left_nxt = window_left_r;
    dest_pos_nxt    = dest_pos_r;
    target_nxt      = target_r;
    out_valid_nxt   = advance ? 1'b0 : out_valid_r;
    out_data_nxt    = out_data_r;

    if (pop) begin
      if (head_cmd.is_start) begin
        target_nxt      = head_cmd.start_pos;
        window_left_nxt = head_cmd.window_count;
        dest_pos_nxt    = '0;
        row_pos_nxt     = '0;
        skip_left_nxt   = '0;
        run_left_nxt    = '0;
        run_is_lit_nxt  = 1'b0;
        phase_nxt       = head_cmd.window_zero ? PH_DONE : PH_HEADER;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            run_is_lit_nxt = !head_cmd.fill_run;
            if (run_end <= {2'b00, target_r}) begin
              // whole run ends at or before the window start
              row_pos_nxt = run_end[14:0];
              if (!head_cmd.fill_run && head_cmd.run_len != 16'd0) begin
                skip_left_nxt = head_cmd.run_len;
                run_left_nxt  = '0;
                phase_nxt     = PH_SKIP;
              end
            end else begin
              row_pos_nxt = target_r;
              if (!head_cmd.fill_run) begin
                skip_left_nxt = {1'b0, offset};
                run_left_nxt  = remain;
                phase_nxt     = (offset != 15'd0) ? PH_SKIP : PH_LIT;
              end else begin
                window_left_nxt          = fill_left;
                out_valid_nxt            = 1'b1;
                out_data_nxt.kind        = KIND_FILL;
                out_data_nxt.word        = fill_value_r;
                out_data_nxt.span_length = fill_cnt;
                out_data_nxt.dest_index  = dest_pos_r;
                out_data_nxt.last        = (fill_left == 10'd0);
                dest_pos_nxt             = dest_pos_r + fill_cnt;
                if (fill_left == 10'd0) begin
                  phase_nxt = PH_DONE;
                end
              end
            end
          end
          PH_SKIP: begin
            skip_left_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = (run_left_r != 16'd0) ? PH_LIT : PH_HEADER;
            end
          end
          PH_LIT: begin
            window_left_nxt          = lit_left;
            run_left_nxt             = run_left_r - 16'd1;
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = KIND_LITERAL;
            out_data_nxt.word        = head_cmd.raw_word;
            out_data_nxt.span_length = 10'd1;
            out_data_nxt.dest_index  = dest_pos_r;
            out_data_nxt.last        = (lit_left == 10'd0);
            dest_pos_nxt             = dest_pos_r + 10'd1;
            if (lit_left == 10'd0) begin
              phase_nxt = PH_DONE;
            end else if (run_left_r == 16'd1) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_IDLE, PH_DONE: begin
            // drop the word
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_value_r  <= '0;
      phase_r       <= PH_IDLE;
      row_pos_r     <= '0;
      skip_left_r   <= '0;
      run_left_r    <= '0;
      run_is_lit_r  <= 1'b0;
      window_left_r <= '0;
      dest_pos_r    <= '0;
      target_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fill_value_r <= cfg_wr_data;
      end
      phase_r       <= phase_nxt;
      row_pos_r     <= row_pos_nxt;
      skip_left_r   <= skip_left_nxt;
      run_left_r    <= run_left_nxt;
      run_is_lit_r  <= run_is_lit_nxt;
      window_left_r <= window_left_nxt;
      dest_pos_r    <= dest_pos_nxt;
      target_r      <= target_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule : rsw_back
`default_nettype wire

FILE: src/rle_span_window_decoder_unit.sv
// Top level of the run-length span window decoder.
//
// Decodes one run-length coded row and emits a window of it. Send a start
// request (op = 0) with start_pos and window_count, then the row's coded
// words (op = 1): a header n >= 0 is followed by n literal words, a header
// n < 0 stands for |n| fill words. Each literal inside the window comes out
// as its own result (span_length 1); each fill run comes out as one span
// carrying the fill_value register, clipped to what is left of the window.
// The window's final result has last set; words after it, and words before
// any start, are dropped until the next start. A zero-width window gives no
// results, and window_count is clipped to MAX_WINDOW - 1.
// Rate: one request per cycle, result or not, unless the output stalls.
// The front classifies each request and writes it into a two-entry queue in
// the cycle it is accepted; the back pops one request per cycle while it
// advances and writes the result register, so each request passes through a
// queue entry and then the result register. The back advances only
// while the result register is empty or being taken, so a stalled output
// backs up through the queue to in_stall.
// Write fill_value only while the block is idle.
`default_nettype none
module rle_span_window_decoder_unit #(
  parameter int MAX_WINDOW = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  rsw_pkg::rsw_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output rsw_pkg::rsw_out_t out_data,
  input  wire               cfg_wr_en,
  input  wire  [15:0]       cfg_wr_data
);
  import rsw_pkg::*;

  rsw_q_status_t q_status;
  rsw_cmd_t      push_cmd;
  rsw_cmd_t      head_cmd;
  logic          push;
  logic          pop;

  // accept and classify requests
  rsw_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple front from back
  rsw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // decode runs and register results
  rsw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_cmd    (head_cmd),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule : rle_span_window_decoder_unit
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the run-length span window decoder unit.
`default_nettype none
module testbench;
  import rsw_pkg::*;

  // Window width limit of the block; window_count is clipped to one below it.
  localparam int MAX_WINDOW = 1024;
  // Let this many cycles pass after the last result before touching fill_value,
  // so that requests which give no result have left the queue and the back end.
  localparam int PIPE_SETTLE = 8;
  // Receiver hold-off long enough to back the queue up into in_stall.
  localparam int RX_HOLD_CYCLES = 300;
  // Limit on the whole run: over a thousand requests plus drains and the
  // hold-off, with a wide margin.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_CAP = 100;

  // Predicts the decoded window results and holds them until the block
  // delivers them.
  class rsw_scoreboard;
    logic [15:0] fill_value;
    rsw_phase_t  phase;
    logic [16:0] row_position;
    logic [15:0] skip_left;
    logic [16:0] run_left;
    logic        run_is_literal;
    logic [10:0] window_left;
    logic [9:0]  dest_pos;
    logic [14:0] target_start;
    rsw_out_t    span_q[$];
    int          mismatches;
    int          results_seen;
    int          requests_seen;

    function new();
      fill_value     = '0;
      phase          = PH_IDLE;
      row_position   = '0;
      skip_left      = '0;
      run_left       = '0;
      run_is_literal = 1'b0;
      window_left    = '0;
      dest_pos       = '0;
      target_start   = '0;
      mismatches     = 0;
      results_seen   = 0;
      requests_seen  = 0;
    endfunction

    function int pending();
      return span_q.size();
    endfunction

    task flag_mismatch(string what);
      if (mismatches < PRINT_CAP)
        $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    // Advance the decoder state by one accepted request.
    function void note_request(rsw_in_t r);
      rsw_out_t    res;
      bit          emit;
      logic [16:0] len;
      logic [17:0] reach;
      logic [16:0] off;
      logic [16:0] rem;
      logic [10:0] cnt;
      logic [10:0] wc;
      emit = 1'b0;
      res  = '0;
      requests_seen++;
      if (r.op == OP_START) begin
        wc = {1'b0, r.window_count};
        if (wc > 11'(MAX_WINDOW - 1))
          wc = 11'(MAX_WINDOW - 1);
        target_start   = r.start_pos;
        window_left    = wc;
        dest_pos       = '0;
        row_position   = '0;
        skip_left      = '0;
        run_left       = '0;
        run_is_literal = 1'b0;
        if (wc == 0)
          phase = PH_DONE;
        else
          phase = PH_HEADER;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (r.data_word[15])
              len = 17'h10000 - {1'b0, r.data_word};
            else
              len = {1'b0, r.data_word};
            run_is_literal = ~r.data_word[15];
            reach = {1'b0, row_position} + {1'b0, len};
            if (reach <= {3'b0, target_start}) begin
              // whole run ends at or before the window start
              row_position = row_position + len;
              if (run_is_literal && len != 0) begin
                skip_left = len[15:0];
                run_left  = '0;
                phase     = PH_SKIP;
              end
            end else begin
              off = {2'b0, target_start} - row_position;
              rem = len - off;
              row_position = {2'b0, target_start};
              if (run_is_literal) begin
                skip_left = off[15:0];
                run_left  = rem;
                if (off != 0)
                  phase = PH_SKIP;
                else
                  phase = PH_LIT;
              end else begin
                if (rem < {6'b0, window_left})
                  cnt = rem[10:0];
                else
                  cnt = window_left;
                window_left     = window_left - cnt;
                res.kind        = KIND_FILL;
                res.word        = fill_value;
                res.span_length = cnt[9:0];
                res.dest_index  = dest_pos;
                res.last        = (window_left == 0);
                emit            = 1'b1;
                dest_pos        = dest_pos + cnt[9:0];
                if (res.last)
                  phase = PH_DONE;
              end
            end
          end
          PH_SKIP: begin
            if (skip_left != 0)
              skip_left = skip_left - 16'd1;
            if (skip_left == 0) begin
              if (run_left != 0)
                phase = PH_LIT;
              else
                phase = PH_HEADER;
            end
          end
          PH_LIT: begin
            window_left     = window_left - 11'd1;
            run_left        = run_left - 17'd1;
            res.kind        = KIND_LITERAL;
            res.word        = r.data_word;
            res.span_length = 10'd1;
            res.dest_index  = dest_pos;
            res.last        = (window_left == 0);
            emit            = 1'b1;
            dest_pos        = dest_pos + 10'd1;
            if (res.last)
              phase = PH_DONE;
            else if (run_left == 0)
              phase = PH_HEADER;
          end
          default: ;
        endcase
      end
      if (emit)
        span_q.push_back(res);
    endfunction

    // Compare one delivered result against the oldest prediction.
    task check_result(rsw_out_t got);
      rsw_out_t want;
      results_seen++;
      if (span_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d word=%h span=%0d dest=%0d last=%0d",
                                got.kind, got.word, got.span_length, got.dest_index, got.last));
      end else begin
        want = span_q.pop_front();
        if (got.kind !== want.kind)
          flag_mismatch($sformatf("result %0d kind %0d, want %0d",
                                  results_seen, got.kind, want.kind));
        if (got.word !== want.word)
          flag_mismatch($sformatf("result %0d word %h, want %h",
                                  results_seen, got.word, want.word));
        if (got.span_length !== want.span_length)
          flag_mismatch($sformatf("result %0d span_length %0d, want %0d",
                                  results_seen, got.span_length, want.span_length));
        if (got.dest_index !== want.dest_index)
          flag_mismatch($sformatf("result %0d dest_index %0d, want %0d",
                                  results_seen, got.dest_index, want.dest_index));
        if (got.last !== want.last)
          flag_mismatch($sformatf("result %0d last %0d, want %0d",
                                  results_seen, got.last, want.last));
      end
    endtask

    task close_out();
      if (span_q.size() != 0)
        flag_mismatch($sformatf("%0d expected results never arrived", span_q.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rsw_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  rsw_out_t    out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  rsw_scoreboard sb;

  // Idling controls, shared between the stimulus and the receiver process.
  bit tx_idle_on;
  bit rx_idle_on;
  int hold_asks;
  int hold_taken;
  int hold_left;
  int items_sent;
  int fills_written;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rle_span_window_decoder_unit #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Receiver: stall at random, except during a requested hold-off, which it
  // counts down itself, or while idling is switched off.
  initial begin
    out_stall  = 1'b1;
    hold_taken = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (rx_idle_on) begin
        out_stall <= ($urandom_range(99) < 38);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sample results at the rising edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_data);
  end

  // Hard stop on a hung block.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // across back-to-back requests; an idle cycle drops it at a falling edge.
  task automatic send_req(rsw_in_t r);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.note_request(r);
    items_sent++;
  endtask

  // Start request; the unused data word carries noise.
  task automatic send_start(int pos, int count);
    rsw_in_t r;
    r.op           = OP_START;
    r.start_pos    = 15'(pos);
    r.window_count = 10'(count);
    r.data_word    = 16'($urandom);
    send_req(r);
  endtask

  // Coded row word; the unused start fields carry noise.
  task automatic send_word(logic [15:0] w);
    rsw_in_t r;
    r.op           = OP_WORD;
    r.start_pos    = 15'($urandom);
    r.window_count = 10'($urandom);
    r.data_word    = w;
    send_req(r);
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // any result-free requests clear the pipe.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write fill_value; only called with the block drained.
  task automatic write_fill(logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.fill_value = v;
    fills_written++;
  endtask

  // One start plus a coded row. Most rows are small and cover their window;
  // a few use full-range start and width and reach them with long fill runs;
  // some are cut short so that the next start abandons them.
  task automatic send_random_row();
    int          start;
    int          count;
    int          covered;
    int          n;
    int          k;
    int          pick;
    bit          wide;
    logic [15:0] hdr;
    wide = ($urandom_range(99) < 6);
    if (wide) begin
      start = $urandom_range(32767);
      count = $urandom_range(1023);
    end else begin
      start = $urandom_range(40);
      count = ($urandom_range(99) < 6) ? 0 : $urandom_range(30, 1);
    end
    send_start(start, count);
    covered = 0;
    while (covered < start + count) begin
      if ($urandom_range(99) < 4)
        break;
      if (wide) begin
        hdr = {1'b1, 15'($urandom)};
        send_word(hdr);
        covered += 65536 - int'(hdr);
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_word(16'h0000);
        end else if (pick < 50) begin
          n = $urandom_range(20, 1);
          send_word(16'(-n));
          covered += n;
        end else begin
          n = $urandom_range(12, 1);
          send_word(16'(n));
          for (k = 0; k < n; k++)
            send_word(16'($urandom));
          covered += n;
        end
      end
    end
    // trailing noise: dropped after the window, decoded if the row was cut
    n = $urandom_range(3);
    for (k = 0; k < n; k++)
      send_word(16'($urandom));
  endtask

  task automatic random_phase(int n, bit pause_midway);
    int goal;
    int half;
    goal = items_sent + n;
    half = items_sent + n / 2;
    while (items_sent < goal) begin
      send_random_row();
      if (pause_midway && items_sent >= half) begin
        pause_midway = 1'b0;
        drain_results();
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_asks     = 0;
    items_sent    = 0;
    fills_written = 0;
    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    write_fill(16'hFFFF);
    // word before any start: drop it
    send_word(16'h7FFF);
    // zero-width window: nothing out, following word dropped
    send_start(0, 0);
    send_word(16'h0003);
    // widest window in one longest fill run, then a word past the window end
    send_start(0, 1023);
    send_word(16'h8000);
    send_word(16'h0000);
    // last start position: fill reaches it by one, empty run, one literal
    send_start(32767, 2);
    send_word(16'h8000);
    send_word(16'h0000);
    send_word(16'h0001);
    send_word(16'h8000);
    // skip into a literal run, emit two, finish on a clipped fill
    send_start(2, 3);
    send_word(16'h0004);
    send_word(16'h1111);
    send_word(16'h2222);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'hFFFB);
    // start mid-window abandons the window
    send_start(0, 5);
    send_word(16'h0001);
    send_word(16'h5A5A);
    // start beyond the row end: keep seeking, nothing out
    send_start(100, 4);
    send_word(16'hFFFD);
    send_word(16'h0002);
    send_word(16'hA5A5);
    send_word(16'h7FFF);
    drain_results();

    // Random phases, each under its own fill value.
    write_fill(16'h0000);
    random_phase(270, 1'b0);
    drain_results();

    // hold the output off while requests keep coming, so in_stall rises
    write_fill(16'($urandom));
    hold_asks++;
    random_phase(270, 1'b0);
    drain_results();

    // no idling at all on either side
    write_fill(16'h8000);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(270, 1'b0);
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // pause the sender mid-phase until everything is back
    write_fill(16'($urandom));
    random_phase(270, 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_SETTLE * 2) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d requests and %0d checked results under %0d fill settings,",
             sb.requests_seen, sb.results_seen, fills_written);
    $display("with a %0d-cycle output hold-off and a stretch with no idling.",
             RX_HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule : testbench
`default_nettype wire
